[rtl/xbs_pkg.sv]
// xbs_pkg: shared constants, phase encoding and helpers for the XMODEM block sender.
// No dependencies.
`timescale 1ns / 1ps
package xbs_pkg;
	localparam int BLOCK_BYTES_DEF = 128;

	localparam logic [7:0] SYM_SOH = 8'h01;
	localparam logic [7:0] SYM_EOT = 8'h04;
	localparam logic [7:0] SYM_ACK = 8'h06;
	localparam logic [7:0] SYM_NAK = 8'h15;
	localparam logic [7:0] SYM_CAN = 8'h18;
	localparam logic [7:0] SYM_PAD = 8'h1A;
	localparam logic [7:0] SYM_C   = 8'h43;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam logic [2:0] OP_START  = 3'd0;
	localparam logic [2:0] OP_RX     = 3'd1;
	localparam logic [2:0] OP_TMO    = 3'd2;
	localparam logic [2:0] OP_SRC    = 3'd3;
	localparam logic [2:0] OP_SLOT   = 3'd4;

	localparam logic [1:0] REG_LEN   = 2'd0;
	localparam logic [1:0] REG_STRY  = 2'd1;
	localparam logic [1:0] REG_BTRY  = 2'd2;
	localparam logic [1:0] REG_ETRY  = 2'd3;

	localparam logic [2:0] ST_BUSY   = 3'd0;
	localparam logic [2:0] ST_OK     = 3'd1;
	localparam logic [2:0] ST_CANCEL = 3'd2;
	localparam logic [2:0] ST_NOSTART= 3'd3;
	localparam logic [2:0] ST_BLKOUT = 3'd4;
	localparam logic [2:0] ST_EOTOUT = 3'd5;

	typedef enum logic [11:0] {
		PH_IDLE       = 12'b000000000001,
		PH_WSTART     = 12'b000000000010,
		PH_WSTART_CAN = 12'b000000000100,
		PH_LOAD       = 12'b000000001000,
		PH_SEND       = 12'b000000010000,
		PH_WACK       = 12'b000000100000,
		PH_WACK_CAN   = 12'b000001000000,
		PH_EOT_SEND   = 12'b000010000000,
		PH_EOT_WAIT   = 12'b000100000000,
		PH_ABORT      = 12'b001000000000,
		PH_CANCEL     = 12'b010000000000,
		PH_DONE       = 12'b100000000000
	} phase_t;

	// CRC-16/XMODEM update over one byte
	function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
		end
		return r;
	endfunction
endpackage

[rtl/xmodem_block_sender_core.sv]
// XMODEM block sender core: control sequencer plus block buffer RAM.
// Depends on xbs_pkg and xbs_ram.
// Only one item is in flight: a new input is not taken until the last one has retired;
// stage 1 issues the buffer read, stage 2
// applies the event, since the data byte of a transmit slot comes from the RAM.
// Reset (arst_n low) clears phase to idle, counters, registers to their defaults.
// The buffer RAM has no reset; only entries written for the current block are read.
`timescale 1ns / 1ps
module xmodem_block_sender_core #(
	parameter int BLOCK_BYTES = xbs_pkg::BLOCK_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  operation,
	input  logic [7:0]  line_byte,
	input  logic [7:0]  source_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        tx_valid,
	output logic [7:0]  tx_byte,
	output logic        source_wanted,
	output logic        finished,
	output logic [2:0]  status,
	output logic [23:0] bytes_sent,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [22:0] cfg_data
);
	import xbs_pkg::*;

	localparam int AW = $clog2(BLOCK_BYTES);
	localparam int CW = AW + 1;

	// configuration registers
	logic [22:0] image_length_q;
	logic [4:0]  start_tries_q, block_tries_q, end_tries_q;

	// state
	phase_t      phase_q;
	logic        crc_mode_q;
	logic [7:0]  block_number_q;
	logic [23:0] acked_q;
	logic [4:0]  try_q;
	logic [7:0]  pos_q;
	logic [CW-1:0] loaded_q;
	logic [15:0] chk_q;
	logic [2:0]  fstat_q;

	// stage 1 holds the accepted item while the buffer read is in flight
	logic        v_s1;
	logic [2:0]  op_s1;
	logic [7:0]  lb_s1, sb_s1;

	// output register
	logic        ov_q;
	logic        txv_q;
	logic [7:0]  txb_q;

	logic out_free;
	assign out_free = !ov_q || !out_stall;
	// one item in flight at a time; stage 2 retires when the output frees
	assign in_stall = v_s1;
	assign cfg_ready = 1'b1;

	// buffer RAM: read address is the data slot of the current send position
	logic           ram_we;
	logic [AW-1:0]  ram_waddr, ram_raddr;
	logic [7:0]     ram_rdata;
	logic [7:0]     pos_m3;
	assign pos_m3 = pos_q - 8'd3;
	assign ram_raddr = pos_m3[AW-1:0];

	xbs_ram #(.WIDTH(8), .DEPTH(BLOCK_BYTES)) u_buf (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(sb_s1),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_length_q <= '0;
			start_tries_q  <= 5'd16;
			block_tries_q  <= 5'd25;
			end_tries_q    <= 5'd10;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LEN:  image_length_q <= cfg_data;
				REG_STRY: start_tries_q  <= cfg_data[4:0];
				REG_BTRY: block_tries_q  <= cfg_data[4:0];
				REG_ETRY: end_tries_q    <= cfg_data[4:0];
				default:  ;
			endcase
		end
	end

	// stage 2 next-state logic
	logic        fire;
	assign fire = v_s1 && out_free;

	phase_t      ph_n;
	logic        crc_n;
	logic [7:0]  bn_n, pos_n, txb_n;
	logic [23:0] ack_n;
	logic [4:0]  try_n;
	logic [CW-1:0] ld_n;
	logic [15:0] chk_n;
	logic [2:0]  fs_n;
	logic        txv_n;

	logic rx, rx_ev;
	logic [24:0] rem;
	logic [CW-1:0] target;
	logic [7:0]  d;
	logic [7:0]  last;
	logic [7:0]  db;
	logic [5:0]  tinc;
	logic [4:0]  lim;

	always_comb begin
		rx    = (op_s1 == OP_RX);
		rx_ev = (op_s1 == OP_RX) || (op_s1 == OP_TMO);
		ph_n = phase_q; crc_n = crc_mode_q; bn_n = block_number_q; ack_n = acked_q;
		try_n = try_q; pos_n = pos_q; ld_n = loaded_q; chk_n = chk_q; fs_n = fstat_q;
		txv_n = 1'b0; txb_n = 8'h00; ram_we = 1'b0; ram_waddr = loaded_q[AW-1:0];
		d = pos_q - 8'd3;
		last = crc_mode_q ? 8'(BLOCK_BYTES + 4) : 8'(BLOCK_BYTES + 3);
		db = 8'h00;
		tinc = {1'b0, try_q} + 6'd1;
		lim = 5'd1;
		case (phase_q)
			PH_WSTART, PH_WSTART_CAN: lim = start_tries_q;
			PH_EOT_WAIT:              lim = end_tries_q;
			default:                  lim = block_tries_q;
		endcase
		if (lim == 5'd0) lim = 5'd1;
		rem = {2'b00, image_length_q} - {1'b0, acked_q};
		target = (rem > 25'(BLOCK_BYTES)) ? CW'(BLOCK_BYTES) : rem[CW-1:0];

		if (op_s1 == OP_START) begin
			crc_n = 1'b0; bn_n = 8'd1; ack_n = '0; try_n = '0; pos_n = '0;
			ld_n = '0; chk_n = '0; fs_n = ST_BUSY; ph_n = PH_WSTART;
		end else begin
			case (phase_q)
				PH_WSTART: if (rx_ev) begin
					if (rx && (lb_s1 == SYM_C || lb_s1 == SYM_NAK)) begin
						crc_n = (lb_s1 == SYM_C); ld_n = '0; try_n = '0; ph_n = PH_LOAD;
					end else if (rx && lb_s1 == SYM_CAN) ph_n = PH_WSTART_CAN;
					else begin
						try_n = tinc[4:0];
						if (tinc[4:0] >= lim) begin
							fs_n = ST_NOSTART; pos_n = '0; ph_n = PH_ABORT;
						end
					end
				end
				PH_WSTART_CAN: if (rx_ev) begin
					if (rx && lb_s1 == SYM_CAN) ph_n = PH_CANCEL;
					else begin
						try_n = tinc[4:0];
						if (tinc[4:0] >= lim) begin
							fs_n = ST_NOSTART; pos_n = '0; ph_n = PH_ABORT;
						end else ph_n = PH_WSTART;
					end
				end
				PH_LOAD: if (op_s1 == OP_SRC && !rem[24] && loaded_q < target
						&& loaded_q < CW'(BLOCK_BYTES)) begin
					ram_we = fire; ld_n = loaded_q + 1'b1;
				end
				PH_SEND: if (op_s1 == OP_SLOT) begin
					txv_n = 1'b1;
					if (pos_q == 8'd0) begin
						chk_n = '0; txb_n = SYM_SOH;
					end else if (pos_q == 8'd1) txb_n = block_number_q;
					else if (pos_q == 8'd2) txb_n = ~block_number_q;
					else if (pos_q < 8'(BLOCK_BYTES + 3)) begin
						if ({1'b0, d} < 9'(loaded_q)) db = ram_rdata;
						else if ({1'b0, d} == 9'(loaded_q)) db = SYM_PAD;
						txb_n = db;
						chk_n = crc_mode_q ? crc_byte(chk_q, db)
							: {8'h00, chk_q[7:0] + db};
					end else if (pos_q == 8'(BLOCK_BYTES + 3))
						txb_n = crc_mode_q ? chk_q[15:8] : chk_q[7:0];
					else txb_n = chk_q[7:0];
					if (pos_q >= last) ph_n = PH_WACK;
					else pos_n = pos_q + 8'd1;
				end
				PH_WACK, PH_WACK_CAN: if (rx_ev) begin
					if (phase_q == PH_WACK && rx && lb_s1 == SYM_ACK) begin
						bn_n = block_number_q + 8'd1;
						ack_n = acked_q + 24'(BLOCK_BYTES);
						ld_n = '0; try_n = '0; ph_n = PH_LOAD;
					end else if (rx && lb_s1 == SYM_CAN) begin
						ph_n = (phase_q == PH_WACK) ? PH_WACK_CAN : PH_CANCEL;
					end else begin
						try_n = tinc[4:0];
						pos_n = '0;
						if (tinc[4:0] >= lim) begin
							fs_n = ST_BLKOUT; ph_n = PH_ABORT;
						end else ph_n = PH_SEND;
					end
				end
				PH_EOT_SEND: if (op_s1 == OP_SLOT) begin
					txv_n = 1'b1; txb_n = SYM_EOT; ph_n = PH_EOT_WAIT;
				end
				PH_EOT_WAIT: if (rx_ev) begin
					if (rx && lb_s1 == SYM_ACK) begin
						fs_n = ST_OK; ph_n = PH_DONE;
					end else begin
						try_n = tinc[4:0];
						if (tinc[4:0] >= lim) begin
							fs_n = ST_EOTOUT; ph_n = PH_DONE;
						end else ph_n = PH_EOT_SEND;
					end
				end
				PH_ABORT: if (op_s1 == OP_SLOT) begin
					txv_n = 1'b1; txb_n = SYM_CAN;
					if (pos_q >= 8'd2) ph_n = PH_DONE;
					else pos_n = pos_q + 8'd1;
				end
				PH_CANCEL: if (op_s1 == OP_SLOT) begin
					txv_n = 1'b1; txb_n = SYM_ACK; fs_n = ST_CANCEL; ph_n = PH_DONE;
				end
				default: ;
			endcase
		end
	end

	// settle: re-evaluate loading against the committed length on every applied item
	logic [24:0] rem_n;
	logic [CW-1:0] tgt_n;
	phase_t ph_f;
	logic [4:0] try_f;
	logic [7:0] pos_f;
	always_comb begin
		rem_n = {2'b00, image_length_q} - {1'b0, ack_n};
		tgt_n = (rem_n > 25'(BLOCK_BYTES)) ? CW'(BLOCK_BYTES) : rem_n[CW-1:0];
		ph_f = ph_n; try_f = try_n; pos_f = pos_n;
		if (ph_n == PH_LOAD) begin
			if (rem_n[24]) begin
				try_f = '0; ph_f = PH_EOT_SEND;
			end else if (ld_n >= tgt_n) begin
				pos_f = '0; ph_f = PH_SEND;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			ov_q <= 1'b0;
			phase_q <= PH_IDLE;
			crc_mode_q <= 1'b0;
			block_number_q <= 8'd1;
			acked_q <= '0;
			try_q <= '0;
			pos_q <= '0;
			loaded_q <= '0;
			chk_q <= '0;
			fstat_q <= ST_BUSY;
		end else begin
			// accept into stage 1; retire when the output register frees
			if (in_valid && !in_stall) v_s1 <= 1'b1;
			else if (fire) v_s1 <= 1'b0;
			if (fire) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
			if (fire) begin
				phase_q <= ph_f; crc_mode_q <= crc_n; block_number_q <= bn_n;
				acked_q <= ack_n; try_q <= try_f; pos_q <= pos_f; loaded_q <= ld_n;
				chk_q <= chk_n; fstat_q <= fs_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1 <= operation; lb_s1 <= line_byte; sb_s1 <= source_byte;
		end
		if (fire) begin
			txv_q <= txv_n; txb_q <= txb_n;
		end
	end

	assign out_valid     = ov_q;
	assign tx_valid      = txv_q;
	assign tx_byte       = txb_q;
	assign source_wanted = (phase_q == PH_LOAD);
	assign finished      = (phase_q == PH_DONE);
	assign status        = (phase_q == PH_DONE) ? fstat_q : ST_BUSY;
	assign bytes_sent    = acked_q;

	// buffer bound, single item in flight, writes only while loading, zero byte without tx
	a_no_load_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		loaded_q <= CW'(BLOCK_BYTES)) else $error("loaded count overflow");
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> in_stall) else $error("second item accepted while busy");
	a_write_in_load: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (phase_q == PH_LOAD)) else $error("buffer write outside load");
	a_tx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !txv_q) |-> (txb_q == 8'h00)) else $error("byte without tx");
endmodule

[rtl/xbs_ram.sv]
// xbs_ram: generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module xbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

[tb/sv/xbs_checker.sv]
// xbs_checker: watches the channels of the XMODEM block sender, predicts every result
// and compares it field by field. Depends on xbs_pkg.
`timescale 1ns / 1ps
module xbs_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  operation,
	input  logic [7:0]  line_byte,
	input  logic [7:0]  source_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        tx_valid,
	input  logic [7:0]  tx_byte,
	input  logic        source_wanted,
	input  logic        finished,
	input  logic [2:0]  status,
	input  logic [23:0] bytes_sent,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [22:0] cfg_data,
	output int          fail_count,
	output int          pending
);
	import xbs_pkg::*;

	typedef struct packed {
		logic        txv;
		logic [7:0]  txb;
		logic        want;
		logic        fin;
		logic [2:0]  st;
		logic [23:0] sent;
	} sender_out_t;

	sender_out_t expected_q[$];

	logic [22:0] image_length;
	logic [4:0]  start_tries, block_tries, end_tries;
	phase_t      phase;
	logic        crc_mode;
	logic [7:0]  block_number;
	logic [23:0] acked_length;
	logic [4:0]  try_count;
	logic [7:0]  send_position;
	logic [7:0]  loaded_count;
	logic [15:0] check_acc;
	logic [7:0]  block_buf [0:127];
	logic [2:0]  final_status;

	assign pending = expected_q.size();

	function automatic logic bump_tries(input logic [4:0] limit);
		try_count = try_count + 5'd1;
		return try_count >= ((limit == 5'd0) ? 5'd1 : limit);
	endfunction

	function automatic logic [23:0] block_target();
		logic [23:0] remaining;
		remaining = {1'b0, image_length} - acked_length;
		return (remaining > 24'd128) ? 24'd128 : remaining;
	endfunction

	function automatic void fold_check(input logic [7:0] b);
		if (crc_mode) begin
			check_acc = check_acc ^ {b, 8'h00};
			for (int k = 0; k < 8; k++)
				check_acc = check_acc[15] ? ((check_acc << 1) ^ CRC_POLY) : (check_acc << 1);
		end else begin
			check_acc = {8'h00, check_acc[7:0] + b};
		end
	endfunction

	function automatic logic [7:0] next_frame_byte();
		logic [7:0] b;
		int p, d, last;
		p = send_position;
		last = crc_mode ? 132 : 131;
		if (p == 0) begin
			check_acc = 16'h0000;
			b = SYM_SOH;
		end else if (p == 1) begin
			b = block_number;
		end else if (p == 2) begin
			b = ~block_number;
		end else if (p < 131) begin
			d = p - 3;
			if (d < loaded_count) b = block_buf[d];
			else if (d == loaded_count) b = SYM_PAD;
			else b = 8'h00;
			fold_check(b);
		end else if (p == 131) begin
			b = crc_mode ? check_acc[15:8] : check_acc[7:0];
		end else begin
			b = check_acc[7:0];
		end
		if (p >= last) phase = PH_WACK;
		else send_position = send_position + 8'd1;
		return b;
	endfunction

	function automatic void start_abort(input logic [2:0] st);
		final_status = st;
		send_position = 8'd0;
		phase = PH_ABORT;
	endfunction

	function automatic void start_load();
		loaded_count = 8'd0;
		try_count = 5'd0;
		phase = PH_LOAD;
	endfunction

	function automatic void retry_block();
		if (bump_tries(block_tries)) begin
			start_abort(ST_BLKOUT);
		end else begin
			send_position = 8'd0;
			phase = PH_SEND;
		end
	endfunction

	// advance the shadow state by one input transfer and return what the block shows
	function automatic sender_out_t advance_sender(input logic [2:0] op, input logic [7:0] lb,
			input logic [7:0] sb);
		sender_out_t r;
		logic is_rx, is_rx_ev;
		is_rx = (op == OP_RX);
		is_rx_ev = (op == OP_RX) || (op == OP_TMO);
		r = '0;
		if (op == OP_START) begin
			crc_mode = 1'b0;
			block_number = 8'd1;
			acked_length = 24'd0;
			try_count = 5'd0;
			send_position = 8'd0;
			loaded_count = 8'd0;
			check_acc = 16'h0000;
			final_status = ST_BUSY;
			phase = PH_WSTART;
		end else begin
			case (phase)
			PH_WSTART: if (is_rx_ev) begin
				if (is_rx && (lb == SYM_C || lb == SYM_NAK)) begin
					crc_mode = (lb == SYM_C);
					start_load();
				end else if (is_rx && lb == SYM_CAN) begin
					phase = PH_WSTART_CAN;
				end else if (bump_tries(start_tries)) begin
					start_abort(ST_NOSTART);
				end
			end
			PH_WSTART_CAN: if (is_rx_ev) begin
				if (is_rx && lb == SYM_CAN) phase = PH_CANCEL;
				else if (bump_tries(start_tries)) start_abort(ST_NOSTART);
				else phase = PH_WSTART;
			end
			PH_LOAD: begin
				if (op == OP_SRC && {1'b0, image_length} >= acked_length
						&& {16'd0, loaded_count} < block_target() && loaded_count < 8'd128) begin
					block_buf[loaded_count[6:0]] = sb;
					loaded_count = loaded_count + 8'd1;
				end
			end
			PH_SEND: if (op == OP_SLOT) begin
				r.txv = 1'b1;
				r.txb = next_frame_byte();
			end
			PH_WACK: if (is_rx_ev) begin
				if (is_rx && lb == SYM_ACK) begin
					block_number = block_number + 8'd1;
					acked_length = acked_length + 24'd128;
					start_load();
				end else if (is_rx && lb == SYM_CAN) begin
					phase = PH_WACK_CAN;
				end else begin
					retry_block();
				end
			end
			PH_WACK_CAN: if (is_rx_ev) begin
				if (is_rx && lb == SYM_CAN) phase = PH_CANCEL;
				else retry_block();
			end
			PH_EOT_SEND: if (op == OP_SLOT) begin
				r.txv = 1'b1;
				r.txb = SYM_EOT;
				phase = PH_EOT_WAIT;
			end
			PH_EOT_WAIT: if (is_rx_ev) begin
				if (is_rx && lb == SYM_ACK) begin
					final_status = ST_OK;
					phase = PH_DONE;
				end else if (bump_tries(end_tries)) begin
					final_status = ST_EOTOUT;
					phase = PH_DONE;
				end else begin
					phase = PH_EOT_SEND;
				end
			end
			PH_ABORT: if (op == OP_SLOT) begin
				r.txv = 1'b1;
				r.txb = SYM_CAN;
				if (send_position >= 8'd2) phase = PH_DONE;
				else send_position = send_position + 8'd1;
			end
			PH_CANCEL: if (op == OP_SLOT) begin
				r.txv = 1'b1;
				r.txb = SYM_ACK;
				final_status = ST_CANCEL;
				phase = PH_DONE;
			end
			default: ;
			endcase
		end
		// the block may become complete, or the data exhausted, on any step
		if (phase == PH_LOAD) begin
			if ({1'b0, image_length} < acked_length) begin
				try_count = 5'd0;
				phase = PH_EOT_SEND;
			end else if ({16'd0, loaded_count} >= block_target()) begin
				send_position = 8'd0;
				phase = PH_SEND;
			end
		end
		r.want = (phase == PH_LOAD);
		r.fin = (phase == PH_DONE);
		r.st = (phase == PH_DONE) ? final_status : ST_BUSY;
		r.sent = acked_length;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sender_out_t exp_r, act_r;
		if (!arst_n) begin
			image_length = '0;
			start_tries = 5'd16;
			block_tries = 5'd25;
			end_tries = 5'd10;
			phase = PH_IDLE;
			crc_mode = 1'b0;
			block_number = 8'd1;
			acked_length = '0;
			try_count = '0;
			send_position = '0;
			loaded_count = '0;
			check_acc = '0;
			final_status = ST_BUSY;
			fail_count = 0;
			expected_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				REG_LEN:  image_length = cfg_data;
				REG_STRY: start_tries = cfg_data[4:0];
				REG_BTRY: block_tries = cfg_data[4:0];
				REG_ETRY: end_tries = cfg_data[4:0];
				default: ;
				endcase
			end
			if (in_valid && !in_stall)
				expected_q.push_back(advance_sender(operation, line_byte, source_byte));
			if (out_valid && !out_stall) begin
				act_r = '{tx_valid, tx_byte, source_wanted, finished, status, bytes_sent};
				if (expected_q.size() == 0) begin
					$error("result transfer with nothing expected");
					fail_count++;
				end else begin
					exp_r = expected_q.pop_front();
					if (act_r.txv !== exp_r.txv) begin
						$error("tx_valid: expected %0h, got %0h", exp_r.txv, act_r.txv);
						fail_count++;
					end
					if (act_r.txb !== exp_r.txb) begin
						$error("tx_byte: expected %0h, got %0h", exp_r.txb, act_r.txb);
						fail_count++;
					end
					if (act_r.want !== exp_r.want) begin
						$error("source_wanted: expected %0h, got %0h", exp_r.want, act_r.want);
						fail_count++;
					end
					if (act_r.fin !== exp_r.fin) begin
						$error("finished: expected %0h, got %0h", exp_r.fin, act_r.fin);
						fail_count++;
					end
					if (act_r.st !== exp_r.st) begin
						$error("status: expected %0h, got %0h", exp_r.st, act_r.st);
						fail_count++;
					end
					if (act_r.sent !== exp_r.sent) begin
						$error("bytes_sent: expected %0h, got %0h", exp_r.sent, act_r.sent);
						fail_count++;
					end
				end
			end
		end
	end
endmodule

[tb/sv/testbench.sv]
// testbench: top of the XMODEM block sender bench; makes stimulus and gives the verdict.
// Depends on xbs_pkg, xmodem_block_sender_core and xbs_checker.
`timescale 1ns / 1ps
module testbench;
	import xbs_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  operation = OP_START;
	logic [7:0]  line_byte = 8'h00;
	logic [7:0]  source_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        tx_valid;
	logic [7:0]  tx_byte;
	logic        source_wanted;
	logic        finished;
	logic [2:0]  status;
	logic [23:0] bytes_sent;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = REG_LEN;
	logic [22:0] cfg_data = '0;
	int          fail_count;
	int          pending;

	// percent of cycles the sender holds off and the receiver stalls
	int idle_pct = 0;
	int stall_pct = 0;
	int items_sent = 0;
	int quiet_cycles = 0;
	int phase_base = 0;
	int next_len = 0;
	localparam int QUIET_LIMIT = 20000;

	always #1 clk = ~clk;

	xmodem_block_sender_core uut (.*);

	xbs_checker chk (.*);

	// randomize the receiver's stall on every falling edge
	always @(negedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	// watchdog: end the run when no transfer of any kind happens for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// one input transfer; called and returns at a falling edge
	task automatic push_event(input logic [2:0] op, input logic [7:0] lb, input logic [7:0] sb);
		while ($urandom_range(99) < idle_pct) begin
			in_valid = 1'b0;
			operation = 3'($urandom_range(7));
			@(negedge clk);
		end
		in_valid = 1'b1;
		operation = op;
		line_byte = lb;
		source_byte = sb;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		in_valid = 1'b0;
		items_sent++;
	endtask

	// rx byte and slot shorthands; unused fields carry random noise
	task automatic rx_byte(input logic [7:0] b);
		push_event(OP_RX, b, 8'($urandom));
	endtask

	task automatic slots(input int n);
		repeat (n) push_event(OP_SLOT, 8'($urandom), 8'($urandom));
	endtask

	// write one register once the block has drained and settled
	task automatic write_reg(input logic [1:0] idx, input logic [22:0] val);
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// a random line reply other than the ones the protocol defines
	function automatic logic [7:0] junk_byte();
		logic [7:0] b;
		do b = 8'($urandom); while (b == SYM_ACK || b == SYM_CAN || b == SYM_C || b == SYM_NAK);
		return b;
	endfunction

	// one full transfer of len bytes with occasional retries, noise and receiver cancels
	task automatic run_transfer(input int len, input logic crc, input int noise_pct);
		int acked, remaining, n;
		acked = 0;
		push_event(OP_START, 8'($urandom), 8'($urandom));
		if ($urandom_range(3) == 0) push_event(OP_TMO, 8'($urandom), 8'($urandom));
		rx_byte(crc ? SYM_C : SYM_NAK);
		while (acked <= len) begin
			remaining = len - acked;
			n = (remaining > 128) ? 128 : remaining;
			repeat (n) begin
				if ($urandom_range(99) < noise_pct)
					push_event(3'($urandom_range(1, 7)), 8'($urandom), 8'($urandom));
				push_event(OP_SRC, 8'($urandom), 8'($urandom));
			end
			slots(crc ? 133 : 132);
			// hold the block for a resend now and then
			case ($urandom_range(9))
			0: begin rx_byte(SYM_NAK); slots(crc ? 133 : 132); end
			1: begin push_event(OP_TMO, 8'h00, 8'h00); slots(crc ? 133 : 132); end
			2: begin rx_byte(junk_byte()); slots(crc ? 133 : 132); end
			3: begin rx_byte(SYM_CAN); rx_byte(junk_byte()); slots(crc ? 133 : 132); end
			default: ;
			endcase
			if ($urandom_range(40) == 0) begin
				// receiver cancels mid-transfer
				rx_byte(SYM_CAN);
				rx_byte(SYM_CAN);
				slots(2);
				return;
			end
			rx_byte(SYM_ACK);
			acked += 128;
		end
		slots(1);
		if ($urandom_range(2) == 0) begin
			push_event(OP_TMO, 8'h00, 8'h00);
			slots(1);
		end
		rx_byte(SYM_ACK);
		slots(1);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// ignored events while idle, then a cancel straight after start
		push_event(3'd5, 8'hFF, 8'hFF);
		push_event(3'd7, 8'h00, 8'h00);
		push_event(OP_SLOT, 8'h00, 8'h00);
		push_event(OP_START, 8'h00, 8'h00);
		rx_byte(SYM_CAN);
		rx_byte(SYM_CAN);
		slots(2);
		push_event(OP_RX, 8'hFF, 8'hFF);

		// zero start tries acts as one: a single timeout aborts with three CANs
		write_reg(REG_STRY, 23'd0);
		push_event(OP_START, 8'h00, 8'h00);
		push_event(OP_TMO, 8'h00, 8'h00);
		slots(4);

		// one block try: a NAK on the padding-only block aborts
		write_reg(REG_BTRY, 23'd1);
		write_reg(REG_STRY, 23'd31);
		push_event(OP_START, 8'h00, 8'h00);
		rx_byte(SYM_C);
		slots(133);
		rx_byte(SYM_NAK);
		slots(3);

		// EOT never acknowledged with one end try; largest image length, start via restart
		write_reg(REG_ETRY, 23'd1);
		write_reg(REG_BTRY, 23'd31);
		write_reg(REG_LEN, 23'd0);
		push_event(OP_START, 8'h00, 8'h00);
		rx_byte(SYM_NAK);
		slots(132);
		rx_byte(SYM_ACK);
		slots(1);
		push_event(OP_TMO, 8'h00, 8'h00);
		write_reg(REG_LEN, 23'h7FFFFF);
		push_event(OP_START, 8'h00, 8'h00);
		rx_byte(SYM_C);
		repeat (5) push_event(OP_SRC, 8'hFF, 8'hFF);
		// shrink the length while loading: the block is re-evaluated
		write_reg(REG_LEN, 23'd5);
		slots(133);
		rx_byte(SYM_ACK);
		slots(1);
		rx_byte(SYM_ACK);

		// random transfers under four idling phases
		write_reg(REG_ETRY, 23'd10);
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
			0: begin idle_pct = 0;  stall_pct = 0;  end
			1: begin idle_pct = 82; stall_pct = 0;  end
			2: begin idle_pct = 0;  stall_pct = 82; end
			default: begin idle_pct = 32; stall_pct = 32; end
			endcase
			phase_base = items_sent;
			while (items_sent - phase_base < 150) begin
				next_len = ($urandom_range(7) == 0) ? 128 : int'($urandom_range(0, 100));
				write_reg(REG_LEN, 23'(next_len));
				write_reg(REG_STRY, 23'($urandom_range(1, 31)));
				write_reg(REG_BTRY, 23'($urandom_range(8, 31)));
				write_reg(REG_ETRY, 23'($urandom_range(2, 31)));
				run_transfer(next_len, 1'($urandom_range(1)), int'($urandom_range(0, 4)));
			end
		end

		// drain, let the pipeline settle, then judge
		while (pending != 0) @(negedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

[filelist.f]
rtl/xbs_pkg.sv
rtl/xbs_ram.sv
rtl/xmodem_block_sender_core.sv
tb/sv/xbs_checker.sv
tb/sv/testbench.sv
